// ===== design/ring_fifo_with_remove_at_index_macros.svh =====
// Assertion macros used by the ring FIFO sequencer RTL.
`ifndef RING_FIFO_WITH_REMOVE_AT_INDEX_MACROS_SVH
`define RING_FIFO_WITH_REMOVE_AT_INDEX_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define RFR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that implies another in the same cycle.
`define RFR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A condition that implies another in the next cycle.
`define RFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rfr_pkg.sv =====
// Shared types, codes and widths of the ring FIFO with removal at a position.
`default_nettype none

package rfr_pkg;

   // Fixed field widths of the command and result beats.
   localparam int CMD_W  = 3;
   localparam int DATA_W = 32;
   localparam int POS_W  = 4;
   localparam int CAP_W  = 5;

   // Defaults for the top-level parameters and the capacity after reset.
   localparam int DEPTH_DEFAULT     = 16;
   localparam int ITEM_BITS_DEFAULT = 32;
   localparam int CAP_RESET         = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_REMOVE = 3'd2,
      CMD_PEEK   = 3'd3,
      CMD_FLUSH  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_EMPTY   = 2'd2,
      STAT_BAD_POS = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_TARGET,
      FSM_MOVE,
      FSM_REPLY
   } fsm_state_type;

   // One result beat.
   typedef struct packed {
      status_type          status;
      logic [DATA_W-1:0]   item;
      logic [CAP_W-1:0]    fill;
      logic                full;
      logic                empty;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/rfr_addr_unit.sv =====
// Shared address unit: maps a logical position to a physical slot.
`default_nettype none

module rfr_addr_unit
   import rfr_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic [$clog2(DEPTH)-1:0] base,
   input  wire logic [CAP_W-1:0]         logical,
   input  wire logic [CAP_W-1:0]         cap,
   output logic      [$clog2(DEPTH)-1:0] phys
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int AW    = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;

   logic [AW-1:0] sum;
   logic [AW-1:0] wrapped;

   // Base is below the capacity and every offset used is at most the capacity, so one subtract wraps the sum.
   always_comb begin
      sum     = AW'(base) + AW'(logical);
      wrapped = (sum >= AW'(cap)) ? (sum - AW'(cap)) : sum;
      phys    = PTR_W'(wrapped);
   end

endmodule

`default_nettype wire

// ===== design/rfr_slot_ram.sv =====
// Slot store: one write port and one registered read port.
`default_nettype none

module rfr_slot_ram #(
   parameter int DEPTH     = 16,
   parameter int ITEM_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [ITEM_BITS-1:0]     wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [ITEM_BITS-1:0]     rdata
);

   logic [ITEM_BITS-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

// ===== design/rfr_ctrl.sv =====
// Command sequencer: pointers, fill count, shifting loop and result register.
`default_nettype none
`include "ring_fifo_with_remove_at_index_macros.svh"

module rfr_ctrl
   import rfr_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int ITEM_BITS = ITEM_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // Command channel.
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [CMD_W-1:0]         req_cmd,
   input  wire logic [DATA_W-1:0]        req_push_data,
   input  wire logic [POS_W-1:0]         req_position,
   // Capacity register write.
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CAP_W-1:0]         csr_capacity,
   // Result channel.
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsp_type                       rsp,
   // Shared address unit.
   output logic      [$clog2(DEPTH)-1:0] au_base,
   output logic      [CAP_W-1:0]         au_logical,
   output logic      [CAP_W-1:0]         au_cap,
   input  wire logic [$clog2(DEPTH)-1:0] au_phys,
   // Slot store.
   output logic                          ram_we,
   output logic      [$clog2(DEPTH)-1:0] ram_waddr,
   output logic      [ITEM_BITS-1:0]     ram_wdata,
   output logic                          ram_re,
   output logic      [$clog2(DEPTH)-1:0] ram_raddr,
   input  wire logic [ITEM_BITS-1:0]     ram_rdata
);

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int AW      = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;
   localparam int CAP_RST = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

   // Control state.
   fsm_state_type          state_ff, state_in;
   logic [PTR_W-1:0]       rp_ff, rp_in;
   logic [CAP_W-1:0]       held_ff, held_in;
   logic [CAP_W-1:0]       cap_ff, cap_in;
   logic [CAP_W-1:0]       left_ff, left_in;
   logic                   wrpend_ff, wrpend_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Payload state.
   cmd_type                cmd_ff, cmd_in;
   logic [DATA_W-1:0]      data_ff, data_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [PTR_W-1:0]       dst_ff, dst_in;
   logic [PTR_W-1:0]       src_ff, src_in;
   logic [CAP_W-1:0]       idx_ff, idx_in;
   logic                   tail_ff, tail_in;
   status_type             stat_ff, stat_in;
   logic [DATA_W-1:0]      item_ff, item_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   req_accept;
   logic                   rsp_free;
   logic [CAP_W-1:0]       pos_ext;
   logic [AW-1:0]          csr_ext;
   logic                   tail_pick;

   assign pos_ext    = CAP_W'(pos_ff);
   assign csr_ext    = AW'(csr_capacity);
   assign tail_pick  = (pos_ext + CAP_W'(1)) > (held_ff >> 1);
   assign req_stall  = (state_ff != FSM_IDLE) || csr_valid;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == FSM_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp        = rsp_ff;

   // The address unit always works from the oldest item.
   assign au_base = rp_ff;
   assign au_cap  = cap_ff;

   // Next state, memory strobes and next values of all registers.
   always_comb begin
      state_in     = state_ff;
      rp_in        = rp_ff;
      held_in      = held_ff;
      cap_in       = cap_ff;
      left_in      = left_ff;
      wrpend_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd_in       = cmd_ff;
      data_in      = data_ff;
      pos_in       = pos_ff;
      dst_in       = dst_ff;
      src_in       = src_ff;
      idx_in       = idx_ff;
      tail_in      = tail_ff;
      stat_in      = stat_ff;
      item_in      = item_ff;
      rsp_in       = rsp_ff;
      au_logical   = '0;
      ram_we       = 1'b0;
      ram_waddr    = dst_ff;
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = au_phys;

      unique case (state_ff)
         FSM_IDLE: begin
            // A capacity write flushes the queue.
            if (csr_valid) begin
               if (csr_ext == '0) begin
                  cap_in = CAP_W'(1);
               end else if (csr_ext > AW'(DEPTH)) begin
                  cap_in = CAP_W'(DEPTH);
               end else begin
                  cap_in = csr_capacity;
               end
               rp_in   = '0;
               held_in = '0;
            end
            if (req_accept) begin
               cmd_in   = cmd_type'(req_cmd);
               data_in  = req_push_data;
               pos_in   = req_position;
               state_in = FSM_EXEC;
            end
         end

         FSM_EXEC: begin
            stat_in  = STAT_OK;
            item_in  = '0;
            state_in = FSM_REPLY;
            unique case (cmd_ff) inside
               CMD_PUSH: begin
                  au_logical = held_ff;
                  if (held_ff >= cap_ff) begin
                     stat_in = STAT_FULL;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = au_phys;
                     ram_wdata = ITEM_BITS'(data_ff);
                     held_in   = held_ff + CAP_W'(1);
                  end
               end
               CMD_POP: begin
                  au_logical = '0;
                  if (held_ff == '0) begin
                     stat_in = STAT_EMPTY;
                  end else begin
                     ram_re   = 1'b1;
                     state_in = FSM_TARGET;
                  end
               end
               CMD_REMOVE, CMD_PEEK: begin
                  au_logical = pos_ext;
                  dst_in     = au_phys;
                  if (held_ff == '0) begin
                     stat_in = STAT_EMPTY;
                  end else if (pos_ext >= held_ff) begin
                     stat_in = STAT_BAD_POS;
                  end else begin
                     ram_re   = 1'b1;
                     state_in = FSM_TARGET;
                  end
               end
               CMD_FLUSH: begin
                  rp_in   = '0;
                  held_in = '0;
               end
               default: begin
                  stat_in = STAT_OK;
               end
            endcase
         end

         FSM_TARGET: begin
            // The addressed item is in the read register now.
            item_in    = DATA_W'(ram_rdata);
            au_logical = CAP_W'(1);
            state_in   = FSM_REPLY;
            if (cmd_ff == CMD_POP) begin
               rp_in   = au_phys;
               held_in = held_ff - CAP_W'(1);
            end else if (cmd_ff == CMD_REMOVE) begin
               // Close the gap from the shorter side.
               tail_in  = tail_pick;
               state_in = FSM_MOVE;
               if (tail_pick) begin
                  left_in = held_ff - pos_ext - CAP_W'(1);
                  idx_in  = pos_ext + CAP_W'(1);
               end else begin
                  left_in = pos_ext;
                  idx_in  = pos_ext - CAP_W'(1);
               end
            end
         end

         FSM_MOVE: begin
            // Each cycle writes the item read last cycle, if any, into the gap and reads
            // the next neighbor while any remain; once written, the slot it came from
            // becomes the next gap.
            ram_we    = wrpend_ff;
            ram_waddr = dst_ff;
            ram_wdata = ram_rdata;
            if (wrpend_ff) begin
               dst_in = src_ff;
            end
            if (left_ff != '0) begin
               au_logical = idx_ff;
               ram_re     = 1'b1;
               src_in     = au_phys;
               idx_in     = tail_ff ? (idx_ff + CAP_W'(1)) : (idx_ff - CAP_W'(1));
               left_in    = left_ff - CAP_W'(1);
               wrpend_in  = 1'b1;
            end else begin
               au_logical = CAP_W'(1);
               if (!tail_ff) begin
                  rp_in = au_phys;
               end
               held_in  = held_ff - CAP_W'(1);
               state_in = FSM_REPLY;
            end
         end

         FSM_REPLY: begin
            if (rsp_free) begin
               rsp_in.status = stat_ff;
               rsp_in.item   = item_ff;
               rsp_in.fill   = held_ff;
               rsp_in.full   = (held_ff == cap_ff);
               rsp_in.empty  = (held_ff == '0);
               rsp_valid_in  = 1'b1;
               state_in      = FSM_IDLE;
            end
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rp_ff        <= '0;
         held_ff      <= '0;
         cap_ff       <= CAP_W'(CAP_RST);
         left_ff      <= '0;
         wrpend_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         held_ff      <= held_in;
         cap_ff       <= cap_in;
         left_ff      <= left_in;
         wrpend_ff    <= wrpend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      data_ff <= data_in;
      pos_ff  <= pos_in;
      dst_ff  <= dst_in;
      src_ff  <= src_in;
      idx_ff  <= idx_in;
      tail_ff <= tail_in;
      stat_ff <= stat_in;
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   // Checks on the sequencer.
   `RFR_ASSERT_ALWAYS(a_held_le_cap, clock, reset, held_ff <= cap_ff,
      "fill count above capacity")
   `RFR_ASSERT_NEXT(a_accept_exec, clock, reset, req_accept, state_ff == FSM_EXEC,
      "accepted beat not executed")
   `RFR_ASSERT_IMPL(a_we_state, clock, reset, ram_we,
      (state_ff == FSM_EXEC) || (state_ff == FSM_MOVE), "slot write outside push or shift")
   `RFR_ASSERT_IMPL(a_rsp_from_reply, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == FSM_REPLY, "result beat not from reply")

endmodule

`default_nettype wire

// ===== design/ring_fifo_with_remove_at_index.sv =====
// Ring FIFO with removal at a logical position: top level.
//
// A circular queue of ITEM_BITS-wide items whose active size is the capacity
// register (0 acts as 1, values above DEPTH act as DEPTH); a capacity write
// flushes the queue. One command is worked on at a time and each gives one
// result beat. Push, flush, unused codes and rejected commands pass through
// the execute and reply states; pop and peek add a state that reads out the
// addressed item; a removal adds that state and then a shift loop over the
// items on the shorter side of the queue around the removed position (at
// most about half the fill count). The single slot-address adder and the
// slot store, with a write port and a registered read port, move one item
// per cycle. A finished result waits in the output register while the next
// command is taken. The store needs no clearing pass after reset.
`default_nettype none

module ring_fifo_with_remove_at_index
   import rfr_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int ITEM_BITS = ITEM_BITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [DATA_W-1:0] req_push_data,
   input  wire logic [POS_W-1:0]  req_position,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CAP_W-1:0]  csr_capacity,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [DATA_W-1:0]      rsp_item_out,
   output logic [CAP_W-1:0]       rsp_fill_count,
   output logic                   rsp_is_full,
   output logic                   rsp_is_empty
);

   localparam int PTR_W = $clog2(DEPTH);

   rsp_type              rsp;
   logic [PTR_W-1:0]     au_base;
   logic [CAP_W-1:0]     au_logical;
   logic [CAP_W-1:0]     au_cap;
   logic [PTR_W-1:0]     au_phys;
   logic                 ram_we;
   logic [PTR_W-1:0]     ram_waddr;
   logic [ITEM_BITS-1:0] ram_wdata;
   logic                 ram_re;
   logic [PTR_W-1:0]     ram_raddr;
   logic [ITEM_BITS-1:0] ram_rdata;

   // Sequencer.
   rfr_ctrl #(
      .DEPTH     (DEPTH),
      .ITEM_BITS (ITEM_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_push_data (req_push_data),
      .req_position  (req_position),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_capacity  (csr_capacity),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp           (rsp),
      .au_base       (au_base),
      .au_logical    (au_logical),
      .au_cap        (au_cap),
      .au_phys       (au_phys),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_re        (ram_re),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata)
   );

   // Shared slot-address adder.
   rfr_addr_unit #(
      .DEPTH (DEPTH)
   ) u_addr (
      .base    (au_base),
      .logical (au_logical),
      .cap     (au_cap),
      .phys    (au_phys)
   );

   // Slot store.
   rfr_slot_ram #(
      .DEPTH     (DEPTH),
      .ITEM_BITS (ITEM_BITS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Result beat fields.
   assign rsp_status     = rsp.status;
   assign rsp_item_out   = rsp.item;
   assign rsp_fill_count = rsp.fill;
   assign rsp_is_full    = rsp.full;
   assign rsp_is_empty   = rsp.empty;

endmodule

`default_nettype wire
